@@ hdl/dhkv_pkg.sv @@
// shared codes and types for the double hash key value table
`timescale 1ns / 1ps
package dhkv_pkg;

   localparam logic [1:0] MARK_FREE = 2'd0;
   localparam logic [1:0] MARK_LIVE = 2'd1;
   localparam logic [1:0] MARK_TOMB = 2'd2;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_ABSENT = 2'd1;
   localparam logic [1:0] STS_FULL   = 2'd2;

   localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
   localparam logic [31:0] MIX_C1 = 32'hc761c23c;
   localparam logic [31:0] MIX_C2 = 32'h165667b1;
   localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
   localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
   localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

   localparam logic [2:0] MIX_LAST = 3'd5;
   localparam logic [1:0] MOD_LAST = 2'd2;

   typedef struct packed {
      logic clr;
      logic load;
      logic mix;
      logic mod;
      logic rd;
      logic adv;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic mix_done;
      logic mod_done;
      logic bad_cmd;
      logic hit;
      logic free;
      logic exhausted;
      logic out_free;
   } dp_sts_type;

endpackage

@@ hdl/dhkv_ctrl.sv @@
// controller state machine sequencing hash, probe walk and commit
`timescale 1ns / 1ps
module dhkv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dhkv_pkg::dp_sts_type sts,
   output dhkv_pkg::dp_cmd_type cmd
);
   import dhkv_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MIX   = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_RD    = 3'd4;
   localparam logic [2:0] ST_CHK   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            if (sts.mix_done) state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod = 1'b1;
            if (sts.mod_done) state_in = sts.bad_cmd ? ST_FIN : ST_RD;
         end
         ST_RD: begin
            cmd.rd = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sts.hit || sts.free || sts.exhausted) begin
               state_in = ST_FIN;
            end else begin
               cmd.adv = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

@@ hdl/dhkv_datapath.sv @@
// datapath: hash mix, reciprocal modulo, slot memories, live count and result register
`timescale 1ns / 1ps
module dhkv_datapath #(
   parameter int CAPACITY = 1021
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dhkv_pkg::dp_cmd_type cmd,
   output dhkv_pkg::dp_sts_type sts,
   input  logic [1:0]           req_command,
   input  logic [31:0]          req_key,
   input  logic [31:0]          req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_read_value,
   output logic [9:0]           rsp_entry_total
);
   import dhkv_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0]   CAP_W    = (AW + 1)'(CAPACITY);
   localparam logic [AW:0]   CAPM1_W  = (AW + 1)'(CAPACITY - 1);
   localparam logic [31:0]   CAP_32   = 32'(CAPACITY);
   localparam logic [31:0]   CAPM1_32 = 32'(CAPACITY - 1);
   localparam logic [31:0]   RECIP1   = 32'(64'hffffffff / CAPACITY);
   localparam logic [31:0]   RECIP2   = 32'(64'hffffffff / (CAPACITY - 1));
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
   localparam logic [CW:0]   LIMIT    = (CW + 1)'((CAPACITY / 4) * 3);

   logic [1:0]    mark_mem  [CAPACITY];
   logic [31:0]   key_mem   [CAPACITY];
   logic [31:0]   value_mem [CAPACITY];

   logic [1:0]    cmd_ff;
   logic [31:0]   key_ff, value_ff, a_ff, a_in;
   logic [2:0]    mix_cnt_ff;
   logic [1:0]    mod_cnt_ff;
   logic [63:0]   prod1, prod2;
   logic [31:0]   q1_ff, q2_ff;
   logic [31:0]   rem1_full, rem2_full;
   logic [AW:0]   rem1_ff, rem2_ff;
   logic [AW-1:0] r1_in, r2_in;
   logic [AW-1:0] pos_ff, step_ff, clr_idx_ff;
   logic [AW:0]   sum;
   logic [CW-1:0] n_ff, count_ff, count_in;
   logic [1:0]    mark_rd_ff;
   logic [31:0]   key_rd_ff, value_rd_ff;
   logic          rsp_valid_ff;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   rd_value_ff, rd_value_in;
   logic [9:0]    total_ff;
   logic [CW+9:0] total_ext;
   logic          mark_we, kv_we, val_we;
   logic [1:0]    mark_wd;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sts.clr_done  = (clr_idx_ff == LAST_IDX);
   assign sts.mix_done  = (mix_cnt_ff == MIX_LAST);
   assign sts.mod_done  = (mod_cnt_ff == MOD_LAST);
   assign sts.bad_cmd   = (cmd_ff != CMD_LOOKUP) && (cmd_ff != CMD_INSERT)
                          && (cmd_ff != CMD_REMOVE);
   assign sts.hit       = (mark_rd_ff == MARK_LIVE) && (key_rd_ff == key_ff);
   assign sts.free      = (mark_rd_ff == MARK_FREE);
   assign sts.exhausted = (n_ff == CAP_CNT);
   assign sts.out_free  = out_free;

   always_comb begin
      case (mix_cnt_ff)
         3'd0:    a_in = (a_ff + MIX_C0) + (a_ff << 12);
         3'd1:    a_in = (a_ff ^ MIX_C1) ^ (a_ff >> 19);
         3'd2:    a_in = (a_ff + MIX_C2) + (a_ff << 5);
         3'd3:    a_in = (a_ff + MIX_C3) ^ (a_ff << 9);
         3'd4:    a_in = (a_ff + MIX_C4) + (a_ff << 3);
         default: a_in = (a_ff ^ MIX_C5) ^ (a_ff >> 16);
      endcase
   end

   // quotient estimate is at most one short, so one correction step remains
   always_comb begin
      prod1 = {32'd0, a_ff} * {32'd0, RECIP1};
      prod2 = {32'd0, a_ff} * {32'd0, RECIP2};
      rem1_full = a_ff - q1_ff * CAP_32;
      rem2_full = a_ff - q2_ff * CAPM1_32;
      r1_in = (rem1_ff >= CAP_W)   ? AW'(rem1_ff - CAP_W)   : AW'(rem1_ff);
      r2_in = (rem2_ff >= CAPM1_W) ? AW'(rem2_ff - CAPM1_W) : AW'(rem2_ff);
      sum = {1'b0, pos_ff} + {1'b0, step_ff};
   end

   always_comb begin
      mark_we = 1'b0;
      kv_we = 1'b0;
      val_we = 1'b0;
      mark_wd = MARK_LIVE;
      count_in = count_ff;
      status_in = STS_ABSENT;
      rd_value_in = '0;
      case (cmd_ff)
         CMD_LOOKUP: begin
            if (sts.hit) begin
               status_in = STS_OK;
               rd_value_in = value_rd_ff;
            end
         end
         CMD_INSERT: begin
            if (sts.hit) begin
               val_we = 1'b1;
               status_in = STS_OK;
            end else if (sts.free && ({1'b0, count_ff} + 1'b1 <= LIMIT)) begin
               mark_we = 1'b1;
               kv_we = 1'b1;
               val_we = 1'b1;
               count_in = count_ff + 1'b1;
               status_in = STS_OK;
            end else begin
               status_in = STS_FULL;
            end
         end
         CMD_REMOVE: begin
            if (sts.hit) begin
               mark_we = 1'b1;
               mark_wd = MARK_TOMB;
               count_in = count_ff - 1'b1;
               status_in = STS_OK;
            end
         end
         default: ;
      endcase
      total_ext = {10'd0, count_in};
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mark_mem[clr_idx_ff] <= MARK_FREE;
      end else if (cmd.commit && mark_we) begin
         mark_mem[pos_ff] <= mark_wd;
      end
      if (cmd.rd) mark_rd_ff <= mark_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && kv_we) key_mem[pos_ff] <= key_ff;
      if (cmd.rd) key_rd_ff <= key_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && val_we) value_mem[pos_ff] <= value_ff;
      if (cmd.rd) value_rd_ff <= value_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         value_ff <= req_value;
         a_ff <= req_key;
      end else if (cmd.mix) begin
         a_ff <= a_in;
      end else if (cmd.mod) begin
         q1_ff <= prod1[63:32];
         q2_ff <= prod2[63:32];
         rem1_ff <= (AW + 1)'(rem1_full);
         rem2_ff <= (AW + 1)'(rem2_full);
         if (sts.mod_done) begin
            pos_ff <= r1_in;
            step_ff <= r2_in + 1'b1;
         end
      end else if (cmd.adv) begin
         pos_ff <= (sum >= CAP_W) ? AW'(sum - CAP_W) : AW'(sum);
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         rd_value_ff <= rd_value_in;
         total_ff <= total_ext[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         mix_cnt_ff <= '0;
         mod_cnt_ff <= '0;
         n_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr && !sts.clr_done) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (cmd.load) mix_cnt_ff <= '0;
         else if (cmd.mix) mix_cnt_ff <= mix_cnt_ff + 1'b1;
         if (cmd.load) mod_cnt_ff <= '0;
         else if (cmd.mod) mod_cnt_ff <= mod_cnt_ff + 1'b1;
         if (cmd.load) n_ff <= '0;
         else if (cmd.rd) n_ff <= n_ff + 1'b1;
         if (cmd.commit) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_read_value = rd_value_ff;
   assign rsp_entry_total = total_ff;

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free) else $error("commit while result register busy");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff) else $error("result not presented after commit");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= LIMIT) else $error("live count above load limit");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> ({1'b0, pos_ff} < CAP_W)) else $error("probe index out of range");

endmodule

@@ hdl/double_hash_key_value_table.sv @@
// top level of the double hash key value table
`timescale 1ns / 1ps
// Key-value store of CAPACITY slots with open addressing and double hashing.
// After reset the block sweeps the slot marks free, one slot a cycle, and
// takes no transaction until that is done. Each transaction then passes
// through accept, the hash mix steps, the reciprocal modulo unit (multiply,
// multiply back and subtract, correct), a probe walk over the slot memories
// (registered read, then compare, for each probe) and commit, with probes
// between 1 and CAPACITY; an unknown command skips the walk. The commit
// step is held for as long as the previous result is still stalled in the
// output register. One transaction is in flight at a time; a finished result
// waits in the output register while the next is accepted.
module double_hash_key_value_table #(
   parameter int CAPACITY = 1021
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_value,
   output logic [9:0]  rsp_entry_total
);
   import dhkv_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   dhkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dhkv_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_total (rsp_entry_total)
   );

endmodule

@@ sim/tb_double_hash_key_value_table.sv @@
// testbench for the double hash key value table checked against a predictor
`timescale 1ns / 1ps
module tb_double_hash_key_value_table;
   import dhkv_pkg::*;

   localparam int CAP = 1021;
   localparam int LOAD_LIMIT = (CAP / 4) * 3;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int RANDOM_COUNT = 250;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_value;
   logic [9:0]  rsp_entry_total;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [9:0]  entry_total;
   } answer_type;

   logic [1:0]  mark_copy [CAP];
   logic [31:0] key_copy [CAP];
   logic [31:0] value_copy [CAP];
   int unsigned live_copy;
   answer_type  pending_answers [$];
   logic [31:0] known_keys [$];
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned stall_left;

   double_hash_key_value_table #(.CAPACITY(CAP)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] mix_key(input logic [31:0] a);
      a = (a + MIX_C0) + (a << 12);
      a = (a ^ MIX_C1) ^ (a >> 19);
      a = (a + MIX_C2) + (a << 5);
      a = (a + MIX_C3) ^ (a << 9);
      a = (a + MIX_C4) + (a << 3);
      a = (a ^ MIX_C5) ^ (a >> 16);
      return a;
   endfunction

   // 1 found, 0 free slot, -1 exhausted
   function automatic int probe_chain(input logic [31:0] k, output int unsigned where);
      logic [31:0] h;
      int unsigned pos;
      int unsigned stride;
      h = mix_key(k);
      pos = h % CAP;
      stride = 1 + h % (CAP - 1);
      where = 0;
      for (int n = 0; n < CAP; n++) begin
         if (mark_copy[pos] == MARK_FREE) begin
            where = pos;
            return 0;
         end
         if (mark_copy[pos] == MARK_LIVE && key_copy[pos] == k) begin
            where = pos;
            return 1;
         end
         pos = pos + stride;
         if (pos >= CAP) pos = pos - CAP;
      end
      return -1;
   endfunction

   function automatic answer_type table_apply(input logic [1:0] cmd, input logic [31:0] k,
                                              input logic [31:0] v);
      answer_type a;
      int r;
      int unsigned where;
      a.status = STS_ABSENT;
      a.read_value = '0;
      if (cmd == CMD_LOOKUP) begin
         r = probe_chain(k, where);
         if (r == 1) begin
            a.status = STS_OK;
            a.read_value = value_copy[where];
         end
      end else if (cmd == CMD_INSERT) begin
         r = probe_chain(k, where);
         if (r == 1) begin
            value_copy[where] = v;
            a.status = STS_OK;
         end else if (r == 0 && live_copy + 1 <= LOAD_LIMIT) begin
            mark_copy[where] = MARK_LIVE;
            key_copy[where] = k;
            value_copy[where] = v;
            live_copy++;
            a.status = STS_OK;
         end else begin
            a.status = STS_FULL;
         end
      end else if (cmd == CMD_REMOVE) begin
         r = probe_chain(k, where);
         if (r == 1) begin
            mark_copy[where] = MARK_TOMB;
            live_copy--;
            a.status = STS_OK;
         end
      end
      a.entry_total = live_copy[9:0];
      return a;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_transaction(input logic [1:0] cmd, input logic [31:0] k,
                                   input logic [31:0] v);
      int unsigned gap;
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_answers.push_back(table_apply(cmd, k, v));
      if (cmd == CMD_INSERT) known_keys.push_back(k);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= k;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      return $urandom();
   endfunction

   task automatic test_directed_edges();
      send_transaction(CMD_LOOKUP, 32'h0, 32'h0);
      send_transaction(CMD_REMOVE, 32'h0, 32'h0);
      send_transaction(CMD_INSERT, 32'h0, 32'hffffffff);
      send_transaction(CMD_INSERT, 32'hffffffff, 32'h0);
      send_transaction(CMD_LOOKUP, 32'h0, 32'h0);
      send_transaction(CMD_LOOKUP, 32'hffffffff, 32'h12345678);
      send_transaction(CMD_INSERT, 32'h0, 32'ha5a5a5a5);
      send_transaction(CMD_LOOKUP, 32'h0, 32'h0);
      send_transaction(CMD_UNKNOWN, 32'h0, 32'hffffffff);
      send_transaction(CMD_REMOVE, 32'h0, 32'h0);
      send_transaction(CMD_LOOKUP, 32'h0, 32'h0);
      send_transaction(CMD_REMOVE, 32'h0, 32'h0);
      send_transaction(CMD_INSERT, 32'h0, 32'h5a5a5a5a);
      send_transaction(CMD_LOOKUP, 32'h0, 32'h0);
      send_transaction(CMD_REMOVE, 32'hffffffff, 32'h0);
   endtask

   // fill up to the load limit, then check refusal and update at the limit
   task automatic test_fill_to_limit();
      logic [31:0] k;
      while (live_copy < LOAD_LIMIT) send_transaction(CMD_INSERT, $urandom(), $urandom());
      for (int i = 0; i < 5; i++) send_transaction(CMD_INSERT, $urandom(), $urandom());
      for (int i = 0; i < 20; i++) begin
         k = pick_key();
         send_transaction(CMD_INSERT, k, $urandom());
         send_transaction(CMD_LOOKUP, k, $urandom());
      end
   endtask

   task automatic test_random_mix();
      logic [1:0] cmd;
      int unsigned p;
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         p = $urandom_range(0, 99);
         if (p < 40) cmd = CMD_INSERT;
         else if (p < 70) cmd = CMD_LOOKUP;
         else if (p < 97) cmd = CMD_REMOVE;
         else cmd = CMD_UNKNOWN;
         send_transaction(cmd, pick_key(), $urandom());
      end
   endtask

   // result side stalls: mostly none, some short runs, a few long runs
   always @(posedge clock) begin
      int unsigned p;
      if (!reset) begin
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            p = $urandom_range(0, 99);
            if (p < 25) stall_left <= $urandom_range(1, 3);
            else if (p < 28) stall_left <= $urandom_range(10, 60);
         end
      end
   end

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected transaction status=%0d", rsp_status);
            error_count++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_read_value !== e.read_value) begin
               $error("read_value expected %h actual %h", e.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_entry_total !== e.entry_total) begin
               $error("entry_total expected %0d actual %0d", e.entry_total,
                      rsp_entry_total);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      cycle_count = 0;
      error_count = 0;
      live_copy = 0;
      stall_left = 0;
      for (int i = 0; i < CAP; i++) mark_copy[i] = MARK_FREE;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_LOOKUP;
      req_key = '0;
      req_value = '0;
      rsp_stall = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_random_mix();
      test_fill_to_limit();
      test_random_mix();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hdl/dhkv_pkg.sv
hdl/dhkv_ctrl.sv
hdl/dhkv_datapath.sv
hdl/double_hash_key_value_table.sv
sim/tb_double_hash_key_value_table.sv
